/* hw/rtl/ivpc_pkg.sv */
// Package: constants, timing tables and pressure conversion for the insufflation valve control.
`default_nettype none

package ivpc_pkg;

	// Regulation tick rate, ticks per second
	localparam int TICKS_PER_SECOND = 200;

	localparam int STEP_MAX     = 40;
	localparam int COUNT_W      = 16;
	localparam int PRESS_W      = 7;
	localparam int FLOW_W       = 6;
	localparam int ADC_W        = 10;
	localparam int CFG_DATA_W   = 8;
	localparam int CFG_ADDR_W   = 2;

	// Pressure conversion limits
	localparam logic [ADC_W-1:0]   ADC_ZERO   = 10'd512;
	localparam logic [ADC_W-1:0]   ADC_FULL   = 10'd922;
	localparam logic [PRESS_W-1:0] PRESS_MAX  = 7'd77;
	// 1/53 as 4947 / 2^18, exact floor for products up to 4090
	localparam logic [12:0]        RECIP_53   = 13'd4947;
	localparam int                 RECIP_SH   = 18;

	// Volume periods per flow band, scaled to the tick rate
	localparam logic [COUNT_W-1:0] VOL_BAND0 = COUNT_W'(4800 * TICKS_PER_SECOND / 200);
	localparam logic [COUNT_W-1:0] VOL_BAND1 = COUNT_W'(2400 * TICKS_PER_SECOND / 200);
	localparam logic [COUNT_W-1:0] VOL_BAND2 = COUNT_W'(2000 * TICKS_PER_SECOND / 200);
	localparam logic [COUNT_W-1:0] VOL_BAND3 = COUNT_W'(1800 * TICKS_PER_SECOND / 200);
	localparam logic [COUNT_W-1:0] VOL_BAND4 = COUNT_W'(1400 * TICKS_PER_SECOND / 200);

	localparam logic [COUNT_W-1:0] CLOSED_TICKS = COUNT_W'(TICKS_PER_SECOND);

	// Configuration register indexes
	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_SET_PRESSURE   = 2'd0,
		CFG_FLOW_INDEX     = 2'd1,
		CFG_AIR_MODE       = 2'd2,
		CFG_EXHAUST_MARGIN = 2'd3
	} cfg_addr_t;

	// Valve open time per flow step, built at elaboration
	typedef logic [COUNT_W-1:0] open_tab_t [0:STEP_MAX];

	function automatic open_tab_t build_open_tab();
		open_tab_t tab;
		int        d;
		for (int s = 0; s <= STEP_MAX; s++) begin
			d = 220 + 20 * s;
			if (d > 1000) begin
				d = 1000;
			end
			tab[s] = COUNT_W'(d * TICKS_PER_SECOND / 200);
		end
		return tab;
	endfunction

	localparam open_tab_t OPEN_TAB = build_open_tab();

	// Flow step limited to the table range
	function automatic logic [FLOW_W-1:0] step_clamp(input logic [FLOW_W-1:0] step);
		return (step > FLOW_W'(STEP_MAX)) ? FLOW_W'(STEP_MAX) : step;
	endfunction

	function automatic logic [COUNT_W-1:0] vol_period(input logic [FLOW_W-1:0] step);
		logic [COUNT_W-1:0] p;
		if (step <= 6'd4) begin
			p = VOL_BAND0;
		end else if (step <= 6'd13) begin
			p = VOL_BAND1;
		end else if (step <= 6'd24) begin
			p = VOL_BAND2;
		end else if (step <= 6'd32) begin
			p = VOL_BAND3;
		end else begin
			p = VOL_BAND4;
		end
		return p;
	endfunction

	// floor((adc - 512) * 10 / 53), clamped to 0..77
	function automatic logic [PRESS_W-1:0] to_mmhg(input logic [ADC_W-1:0] adc);
		logic [8:0]     d;
		logic [11:0]    x;
		logic [24:0]    prod;
		logic [PRESS_W-1:0] q;
		d    = 9'(adc - ADC_ZERO);
		x    = {d, 3'b000} + {2'b00, d, 1'b0};
		prod = 25'(x) * 25'(RECIP_53);
		q    = prod[RECIP_SH +: PRESS_W];
		if (adc <= ADC_ZERO) begin
			q = '0;
		end else if (adc >= ADC_FULL || q > PRESS_MAX) begin
			q = PRESS_MAX;
		end
		return q;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/insufflation_valve_pressure_control_unit.sv */
// Top level: insufflation valve and pump regulation, one tick request per cycle unless out_ready stalls.
`default_nettype none

//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  in      | input     | in_valid/in_ready  | adc_sample, running
//  out     | output    | out_valid/out_ready| control_valve, exhaust_valve, air_pump,
//          |           |                    | pressure_mmhg, flow_shown, volume_count
//  cfg     | input     | cfg_we             | cfg_addr, cfg_wdata
//
// Each tick request is evaluated combinationally: the state and the result register
// load at the edge that accepts it, so one request per cycle is sustained
// while out_ready is high. The result register holds one result; a new request
// is taken while it waits as long as out_ready frees it in the same cycle.
// arst_n clears all state but the result payload, and the result valid; exhaust margin resets to 2.

module insufflation_valve_pressure_control_unit
	import ivpc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  cfg_we,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,

	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [ADC_W-1:0]      adc_sample,
	input  wire logic                  running,

	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       control_valve,
	output logic                       exhaust_valve,
	output logic                       air_pump,
	output logic [PRESS_W-1:0]         pressure_mmhg,
	output logic [FLOW_W-1:0]          flow_shown,
	output logic [COUNT_W-1:0]         volume_count
);

	// Configuration registers
	logic [7:0]        set_pressure_q;
	logic [FLOW_W-1:0] flow_index_q;
	logic              air_mode_q;
	logic [3:0]        exhaust_margin_q;

	// Regulation state
	logic [PRESS_W-1:0] held_q;
	logic               valve_q, exhaust_q, pump_q;
	logic [COUNT_W-1:0] open_q, closed_q, vol_q, litres_q;
	logic [FLOW_W-1:0]  flow_q;

	// Next state
	logic [PRESS_W-1:0] held_d;
	logic               valve_d, exhaust_d, pump_d;
	logic [COUNT_W-1:0] open_d, closed_d, vol_d, litres_d;
	logic [FLOW_W-1:0]  flow_d;

	logic               out_valid_q;
	logic               accept;
	logic [PRESS_W-1:0] sample_mmhg;
	logic [FLOW_W-1:0]  step;
	logic [8:0]         exhaust_lim;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	assign sample_mmhg = to_mmhg(adc_sample);
	assign step        = step_clamp(flow_index_q);
	assign exhaust_lim = {1'b0, set_pressure_q} + {5'b0, exhaust_margin_q};

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_pressure_q   <= '0;
			flow_index_q     <= '0;
			air_mode_q       <= 1'b0;
			exhaust_margin_q <= 4'd2;
		end else if (cfg_we) begin
			unique case (cfg_addr_t'(cfg_addr))
				CFG_SET_PRESSURE:   set_pressure_q   <= cfg_wdata;
				CFG_FLOW_INDEX:     flow_index_q     <= cfg_wdata[FLOW_W-1:0];
				CFG_AIR_MODE:       air_mode_q       <= cfg_wdata[0];
				CFG_EXHAUST_MARGIN: exhaust_margin_q <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	// Tick evaluation: counters advance, then the regulation rule or the stop clear applies
	always_comb begin
		held_d    = held_q;
		valve_d   = valve_q;
		exhaust_d = exhaust_q;
		pump_d    = pump_q;
		litres_d  = litres_q;
		flow_d    = flow_q;
		open_d    = (open_q   == '1) ? open_q   : open_q   + 1'b1;
		closed_d  = (closed_q == '1) ? closed_q : closed_q + 1'b1;
		vol_d     = (vol_q    == '1) ? vol_q    : vol_q    + 1'b1;

		if (!running) begin
			// stop: drives off, tick counters and shown flow cleared
			valve_d   = 1'b0;
			exhaust_d = 1'b0;
			pump_d    = 1'b0;
			open_d    = '0;
			closed_d  = '0;
			vol_d     = '0;
			flow_d    = '0;
		end else if ({1'b0, held_q} <= set_pressure_q) begin
			exhaust_d = 1'b0;
			if (!air_mode_q) begin
				if (valve_q) begin
					if (open_d >= OPEN_TAB[step]) begin
						valve_d  = 1'b0;
						flow_d   = flow_index_q;
						closed_d = '0;
					end
				end else if (closed_d >= CLOSED_TICKS) begin
					// resample before reopening
					held_d = sample_mmhg;
					if ({1'b0, sample_mmhg} <= set_pressure_q) begin
						valve_d = 1'b1;
						open_d  = '0;
					end
				end
				if (vol_d > vol_period(step)) begin
					litres_d = (litres_q == '1) ? litres_q : litres_q + 1'b1;
					vol_d    = '0;
				end
			end else begin
				pump_d = 1'b1;
				flow_d = flow_index_q;
				held_d = sample_mmhg;
			end
		end else begin
			// over set point
			held_d = sample_mmhg;
			if (!air_mode_q) begin
				valve_d = 1'b0;
				vol_d   = '0;
			end else begin
				pump_d = 1'b0;
				flow_d = '0;
			end
			if ({2'b00, sample_mmhg} >= exhaust_lim) begin
				exhaust_d = 1'b1;
			end
		end
	end

	// State update on each accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q    <= '0;
			valve_q   <= 1'b0;
			exhaust_q <= 1'b0;
			pump_q    <= 1'b0;
			open_q    <= '0;
			closed_q  <= '0;
			vol_q     <= '0;
			litres_q  <= '0;
			flow_q    <= '0;
		end else if (accept) begin
			held_q    <= held_d;
			valve_q   <= valve_d;
			exhaust_q <= exhaust_d;
			pump_q    <= pump_d;
			open_q    <= open_d;
			closed_q  <= closed_d;
			vol_q     <= vol_d;
			litres_q  <= litres_d;
			flow_q    <= flow_d;
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			control_valve <= valve_d;
			exhaust_valve <= exhaust_d;
			air_pump      <= pump_d;
			pressure_mmhg <= held_d;
			flow_shown    <= flow_d;
			volume_count  <= litres_d;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

/* bench/insufflation_valve_pressure_control_unit_tb.sv */
// Testbench for the insufflation valve control: directed and random ticks checked against a predictor.
module insufflation_valve_pressure_control_unit_tb import ivpc_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	// One tick result, fields in port order
	typedef struct packed {
		logic               valve;
		logic               exhaust;
		logic               pump;
		logic [PRESS_W-1:0] press;
		logic [FLOW_W-1:0]  flow;
		logic [COUNT_W-1:0] litres;
	} tick_result_t;

	// Regulation predictor plus the queue of results still to come
	class valve_scoreboard;
		logic [7:0]         set_press;
		logic [FLOW_W-1:0]  flow_step;
		logic               air;
		logic [3:0]         margin;
		logic [PRESS_W-1:0] held;
		logic               valve, exhaust, pump;
		logic [COUNT_W-1:0] open_cnt, closed_cnt, vol_cnt, litres;
		logic [FLOW_W-1:0]  shown;
		tick_result_t       pending[$];
		int                 errors;

		function new();
			set_press = '0;
			flow_step = '0;
			air = 1'b0;
			margin = 4'd2;
			held = '0;
			valve = 1'b0;
			exhaust = 1'b0;
			pump = 1'b0;
			open_cnt = '0;
			closed_cnt = '0;
			vol_cnt = '0;
			litres = '0;
			shown = '0;
			errors = 0;
		endfunction

		function void write_reg(cfg_addr_t idx, logic [7:0] val);
			case (idx)
				CFG_SET_PRESSURE:   set_press = val;
				CFG_FLOW_INDEX:     flow_step = val[FLOW_W-1:0];
				CFG_AIR_MODE:       air = val[0];
				CFG_EXHAUST_MARGIN: margin = val[3:0];
				default: ;
			endcase
		endfunction

		// Raw ADC to mmHg, floored and clamped to the scale
		function int mmhg_of(int adc);
			int p;
			if (adc <= 512) return 0;
			if (adc >= 922) return 77;
			p = (adc - 512) * 10 / 53;
			return (p > 77) ? 77 : p;
		endfunction

		function int step_lim();
			return (flow_step > STEP_MAX) ? STEP_MAX : int'(flow_step);
		endfunction

		function int open_time();
			int d;
			d = 220 + 20 * step_lim();
			if (d > 1000) d = 1000;
			return d * TICKS_PER_SECOND / 200;
		endfunction

		function int vol_period();
			int s, d;
			s = step_lim();
			if (s <= 4) d = 4800;
			else if (s <= 13) d = 2400;
			else if (s <= 24) d = 2000;
			else if (s <= 32) d = 1800;
			else d = 1400;
			return d * TICKS_PER_SECOND / 200;
		endfunction

		function logic [COUNT_W-1:0] bump(logic [COUNT_W-1:0] v);
			return (v == '1) ? v : v + 1'b1;
		endfunction

		// Regulation rule for a running tick
		function void regulate(int adc);
			if (held <= set_press) begin
				exhaust = 1'b0;
				if (!air) begin
					if (valve) begin
						if (open_cnt >= open_time()) begin
							valve = 1'b0;
							shown = flow_step;
							closed_cnt = '0;
						end
					end else if (closed_cnt >= TICKS_PER_SECOND) begin
						held = PRESS_W'(mmhg_of(adc));
						if (held <= set_press) begin
							valve = 1'b1;
							open_cnt = '0;
						end
					end
					if (vol_cnt > vol_period()) begin
						litres = bump(litres);
						vol_cnt = '0;
					end
				end else begin
					pump = 1'b1;
					shown = flow_step;
					held = PRESS_W'(mmhg_of(adc));
				end
			end else begin
				held = PRESS_W'(mmhg_of(adc));
				if (!air) begin
					valve = 1'b0;
					vol_cnt = '0;
				end else begin
					pump = 1'b0;
					shown = '0;
				end
				if (int'(held) >= int'(set_press) + int'(margin)) exhaust = 1'b1;
			end
		endfunction

		// Accepted tick request: advance the model, queue its result
		function void note_request(logic [ADC_W-1:0] adc, logic run);
			tick_result_t r;
			if (run) begin
				open_cnt = bump(open_cnt);
				closed_cnt = bump(closed_cnt);
				vol_cnt = bump(vol_cnt);
				regulate(int'(adc));
			end else begin
				valve = 1'b0;
				exhaust = 1'b0;
				pump = 1'b0;
				open_cnt = '0;
				closed_cnt = '0;
				vol_cnt = '0;
				shown = '0;
			end
			r.valve = valve;
			r.exhaust = exhaust;
			r.pump = pump;
			r.press = held;
			r.flow = shown;
			r.litres = litres;
			pending.push_back(r);
		endfunction

		task report(string msg);
			if (errors < 40) $display("tb: mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(tick_result_t got);
			tick_result_t exp;
			if (pending.size() == 0) begin
				report("result with no tick pending");
				return;
			end
			exp = pending.pop_front();
			if (got.valve !== exp.valve)
				report($sformatf("control_valve %0d, predicted %0d", got.valve, exp.valve));
			if (got.exhaust !== exp.exhaust)
				report($sformatf("exhaust_valve %0d, predicted %0d", got.exhaust, exp.exhaust));
			if (got.pump !== exp.pump)
				report($sformatf("air_pump %0d, predicted %0d", got.pump, exp.pump));
			if (got.press !== exp.press)
				report($sformatf("pressure_mmhg %0d, predicted %0d", got.press, exp.press));
			if (got.flow !== exp.flow)
				report($sformatf("flow_shown %0d, predicted %0d", got.flow, exp.flow));
			if (got.litres !== exp.litres)
				report($sformatf("volume_count %0d, predicted %0d", got.litres, exp.litres));
		endtask

		function bit drained();
			return pending.size() == 0;
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [ADC_W-1:0]      adc_sample = '0;
	logic                  running = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  control_valve;
	logic                  exhaust_valve;
	logic                  air_pump;
	logic [PRESS_W-1:0]    pressure_mmhg;
	logic [FLOW_W-1:0]     flow_shown;
	logic [COUNT_W-1:0]    volume_count;

	valve_scoreboard sb = new();

	logic gaps_on = 1'b1;   // idling on both sides
	int   hold_req = 0;     // bumped to ask the receiver for a long hold-off

	insufflation_valve_pressure_control_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.adc_sample    (adc_sample),
		.running       (running),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.control_valve (control_valve),
		.exhaust_valve (exhaust_valve),
		.air_pump      (air_pump),
		.pressure_mmhg (pressure_mmhg),
		.flow_shown    (flow_shown),
		.volume_count  (volume_count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Idle length: mostly short, now and then a long one
	function automatic int gap_len();
		if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Result side: check what is taken, then pick ready for the next edge
	int rx_stall = 0;
	int hold_seen = 0;
	int hold_left = 0;
	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_result({control_valve, exhaust_valve, air_pump,
				pressure_mmhg, flow_shown, volume_count});
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = 80;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (rx_stall > 0) begin
			rx_stall--;
			out_ready <= 1'b0;
		end else if (gaps_on && $urandom_range(0, 3) == 0) begin
			rx_stall = gap_len() - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Offer one tick request and wait for it to be taken
	task automatic send_tick(input logic [ADC_W-1:0] adc, input logic run);
		int gap;
		gap = 0;
		if (gaps_on && $urandom_range(0, 2) == 0) gap = gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		adc_sample <= adc;
		running <= run;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_request(adc, run);
	endtask

	// Stop offering and wait for every outstanding result
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (!sb.drained());
	endtask

	task automatic put_reg(input cfg_addr_t idx, input logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	// Write all four registers; only called with the block idle
	task automatic configure(input logic [7:0] sp, input logic [7:0] fl,
			input logic [7:0] am, input logic [7:0] mg);
		put_reg(CFG_SET_PRESSURE, sp);
		put_reg(CFG_FLOW_INDEX, fl);
		put_reg(CFG_AIR_MODE, am);
		put_reg(CFG_EXHAUST_MARGIN, mg);
		cfg_we <= 1'b0;
	endtask

	// Main sequence
	initial begin
		int         n, k, len, r, tgt, adc;
		logic [7:0] sp, fl;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings, CO2 mode, scale ends and a stop
		send_tick(10'd0, 1'b1);
		send_tick(10'd1023, 1'b1);
		send_tick(10'd512, 1'b0);
		send_tick(10'd513, 1'b1);
		drain();

		// Air mode: pump control, exhaust opening and its hysteresis
		configure(8'd10, 8'd40, 8'd1, 8'd15);
		send_tick(10'd512, 1'b1);
		send_tick(10'd1023, 1'b1);
		send_tick(10'd600, 1'b1);
		send_tick(10'd922, 1'b1);
		send_tick(10'd921, 1'b1);
		send_tick(10'd565, 1'b1);
		send_tick(10'd0, 1'b1);
		drain();

		// Switch to CO2 while running: pump keeps its state
		configure(8'd10, 8'd63, 8'd0, 8'd0);
		send_tick(10'd700, 1'b1);
		send_tick(10'd1023, 1'b1);
		drain();

		// Flow step above the table, zero set point and margin
		configure(8'd0, 8'd63, 8'd1, 8'd0);
		send_tick(10'd1023, 1'b1);
		send_tick(10'd1023, 1'b1);
		send_tick(10'd511, 1'b1);
		send_tick(10'd300, 1'b1);
		send_tick(10'd0, 1'b0);
		drain();
		configure(8'd255, 8'd0, 8'd0, 8'd15);
		send_tick(10'd1023, 1'b1);
		send_tick(10'd800, 1'b0);
		drain();

		// Receiver holds off while requests keep coming
		hold_req <= hold_req + 1;
		for (n = 0; n < 30; n++) send_tick(ADC_W'($urandom_range(0, 1023)), 1'b1);
		drain();

		// CO2 pulsing: reopen after the closed second, then close after the open time
		configure(8'd255, 8'd0, 8'd0, 8'($urandom_range(0, 15)));
		for (n = 0; n < 430; n++) send_tick(ADC_W'($urandom_range(0, 1023)), 1'b1);
		drain();

		// Random phases: pressures mostly around the set point
		n = 0;
		while (n < 60) begin
			r = $urandom_range(0, 9);
			sp = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom_range(0, 80));
			r = $urandom_range(0, 9);
			fl = (r == 0) ? 8'd0 : (r == 1) ? 8'd40 : (r == 2) ? 8'd63 :
				8'($urandom_range(0, 63));
			gaps_on <= ($urandom_range(0, 3) != 0);
			configure(sp, fl, 8'($urandom_range(0, 1)), 8'($urandom_range(0, 15)));
			tgt = (sp > 77) ? 77 : int'(sp);
			len = $urandom_range(20, 60);
			for (k = 0; k < len; k++) begin
				r = $urandom_range(0, 99);
				if (r < 1) begin
					send_tick(ADC_W'($urandom_range(0, 1023)), 1'b0);
				end else if (r < 21) begin
					send_tick(ADC_W'($urandom_range(0, 1023)), 1'b1);
				end else begin
					adc = 512 + tgt * 53 / 10 + $urandom_range(0, 24) - 12;
					send_tick(ADC_W'(adc), 1'b1);
				end
				n++;
			end
			drain();
		end

		repeat (4) @(posedge clk);
		if (sb.errors == 0 && sb.drained()) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Run limit
	initial begin
		#50ms;
		$display("tb: failure");
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/ivpc_pkg.sv
hw/rtl/insufflation_valve_pressure_control_unit.sv
bench/insufflation_valve_pressure_control_unit_tb.sv
